/* src/atbc_pkg.sv */
package atbc_pkg;

    localparam int unsigned WORD_W = 32;

    typedef enum logic [1:0] {
        K_LOAD = 2'd0,
        K_ENC  = 2'd1,
        K_DEC  = 2'd2,
        K_NONE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_WAIT,
        S_STEP,
        S_OUT
    } t_state;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        logic  dec;
        logic  first;
        logic  last;
        logic  odd;
    } t_ctrl;

    localparam t_word RCON [8] = '{
        32'hB7E15162, 32'hBF715880, 32'h38B4DA56, 32'h324E7738,
        32'hBB1185EB, 32'h4F7C7B57, 32'hCFBFA1C8, 32'hC2B3293D
    };

    function automatic t_word ror(input t_word v, input int unsigned r);
        ror = (v >> r) | (v << (WORD_W - r));
    endfunction

    function automatic t_word ell(input t_word v);
        ell = ror(v ^ (v << 16), 16);
    endfunction

    function automatic logic [63:0] box_fwd(input logic [63:0] b, input t_word c);
        t_word x;
        t_word y;
        x = b[63:32];
        y = b[31:0];
        x = x + ror(y, 31); y = y ^ ror(x, 24); x = x ^ c;
        x = x + ror(y, 17); y = y ^ ror(x, 17); x = x ^ c;
        x = x + y;          y = y ^ ror(x, 31); x = x ^ c;
        x = x + ror(y, 24); y = y ^ ror(x, 16); x = x ^ c;
        box_fwd = {x, y};
    endfunction

    function automatic logic [63:0] box_inv(input logic [63:0] b, input t_word c);
        t_word x;
        t_word y;
        x = b[63:32];
        y = b[31:0];
        x = x ^ c; y = y ^ ror(x, 16); x = x - ror(y, 24);
        x = x ^ c; y = y ^ ror(x, 31); x = x - y;
        x = x ^ c; y = y ^ ror(x, 17); x = x - ror(y, 17);
        x = x ^ c; y = y ^ ror(x, 24); x = x - ror(y, 31);
        box_inv = {x, y};
    endfunction

endpackage

/* src/atbc_if.sv */
interface atbc_if #(
    parameter int unsigned W = 64
) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* src/atbc_keystore.sv */
module atbc_keystore #(
    parameter int unsigned DEPTH = 144,
    parameter int unsigned AW    = 8
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [AW-1:0]        i_waddr,
    input  atbc_pkg::t_word      i_wdata,
    input  logic [AW-4:0]        i_row,
    output logic [8*32-1:0]      o_row
);
    localparam int unsigned ROWS = DEPTH / 8;

    atbc_pkg::t_word mem [ROWS][8];
    integer k;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr[AW-1:3]][i_waddr[2:0]] <= i_wdata;
        end
    end

    // one row of 8 words read at a single address, registered
    always_ff @(posedge i_clk) begin
        for (k = 0; k < 8; k++) begin
            o_row[(7-k)*32 +: 32] <= mem[i_row][k];
        end
    end
endmodule

/* src/atbc_round.sv */
module atbc_round (
    input  atbc_pkg::t_ctrl i_ctrl,
    input  logic [255:0]    i_state,
    input  logic [255:0]    i_keys,
    input  logic [127:0]    i_tweak,
    output logic [255:0]    o_state
);
    atbc_pkg::t_word x [4];
    atbc_pkg::t_word y [4];
    atbc_pkg::t_word t;
    atbc_pkg::t_word x0;
    atbc_pkg::t_word x1;
    atbc_pkg::t_word y0;
    atbc_pkg::t_word y1;
    logic [63:0]     b;
    integer j;

    always_comb begin
        for (j = 0; j < 4; j++) begin
            x[j] = i_state[(3-j)*64+32 +: 32];
            y[j] = i_state[(3-j)*64 +: 32];
        end
        t = '0; x0 = '0; x1 = '0; y0 = '0; y1 = '0; b = '0;
        if (!i_ctrl.dec) begin
            if (i_ctrl.odd && !i_ctrl.last) begin
                x[0] ^= i_tweak[127:96]; y[0] ^= i_tweak[95:64];
                x[1] ^= i_tweak[63:32];  y[1] ^= i_tweak[31:0];
            end
            for (j = 0; j < 4; j++) begin
                x[j] ^= i_keys[(7-2*j)*32 +: 32];
                y[j] ^= i_keys[(6-2*j)*32 +: 32];
            end
            if (!i_ctrl.last) begin
                for (j = 0; j < 4; j++) begin
                    b = atbc_pkg::box_fwd({x[j], y[j]},
                        atbc_pkg::RCON[(i_ctrl.odd ? 4 : 0) + j]);
                    x[j] = b[63:32]; y[j] = b[31:0];
                end
                t = atbc_pkg::ell(x[2] ^ x[3]); y[0] ^= t; y[1] ^= t;
                t = atbc_pkg::ell(y[2] ^ y[3]); x[0] ^= t; x[1] ^= t;
                x0 = x[0]; x1 = x[1]; y0 = y[0]; y1 = y[1];
                x[0] = x[3]; x[1] = x[2]; x[2] = x0; x[3] = x1;
                y[0] = y[3]; y[1] = y[2]; y[2] = y0; y[3] = y1;
            end
        end else begin
            if (!i_ctrl.first) begin
                x0 = x[0]; x1 = x[1]; y0 = y[0]; y1 = y[1];
                x[0] = x[2]; x[1] = x[3]; x[2] = x1; x[3] = x0;
                y[0] = y[2]; y[1] = y[3]; y[2] = y1; y[3] = y0;
                t = atbc_pkg::ell(y[2] ^ y[3]); x[0] ^= t; x[1] ^= t;
                t = atbc_pkg::ell(x[2] ^ x[3]); y[0] ^= t; y[1] ^= t;
                for (j = 0; j < 4; j++) begin
                    b = atbc_pkg::box_inv({x[j], y[j]},
                        atbc_pkg::RCON[(i_ctrl.odd ? 4 : 0) + j]);
                    x[j] = b[63:32]; y[j] = b[31:0];
                end
            end
            for (j = 0; j < 4; j++) begin
                x[j] ^= i_keys[(7-2*j)*32 +: 32];
                y[j] ^= i_keys[(6-2*j)*32 +: 32];
            end
            if (i_ctrl.odd && !i_ctrl.first) begin
                x[0] ^= i_tweak[127:96]; y[0] ^= i_tweak[95:64];
                x[1] ^= i_tweak[63:32];  y[1] ^= i_tweak[31:0];
            end
        end
        for (j = 0; j < 4; j++) begin
            o_state[(3-j)*64 +: 64] = {x[j], y[j]};
        end
    end
endmodule

/* src/arx_tweakable_block_cipher_256.sv */
// tweakable 256-bit arx block cipher, steps run one after another through a shared step unit
// input channel i_in: payload {kind, key_index, key_word, branch0..3}, 298 bits
// output channel o_out: payload {branch0_out..branch3_out}, 256 bits
// config port: i_cfg_we, i_cfg_idx (0 tweak_branch0, 1 tweak_branch1), i_cfg_data
// a load transaction writes one subkey word (only if key_index < DEPTH) and gives no result
// kind 3 is dropped
// an encrypt or decrypt transaction runs its steps one after another before the result:
// each step fetches a registered 8-word subkey row, then runs the step unit
// the result is held in an output register until taken; the input is not
// ready until then, so a stalled receiver stalls the block
// reset clears the state, the step counter and the tweaks; the subkey store is undefined until loaded
// subkey words must be loaded before any cipher transaction uses them
module arx_tweakable_block_cipher_256 #(
    parameter int unsigned STEPS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    atbc_if.sink        i_in,
    atbc_if.source      o_out
);
    localparam int unsigned DEPTH = 8 * (STEPS + 1);
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam int unsigned SW    = AW - 3;

    atbc_pkg::t_state r_state, n_state;
    logic [SW-1:0]    r_step, n_step;
    logic             r_dec;
    logic [255:0]     r_data;
    logic [127:0]     r_tweak;
    logic [255:0]     keys;
    logic [255:0]     step_out;
    atbc_pkg::t_ctrl  ctrl;
    atbc_pkg::t_kind  kind;
    logic [7:0]       kidx;
    logic             acc;
    logic             we;

    assign kind = atbc_pkg::t_kind'(i_in.payload[297:296]);
    assign kidx = i_in.payload[295:288];
    assign acc  = i_in.valid && i_in.ready;
    assign we   = acc && kind == atbc_pkg::K_LOAD && {1'b0, kidx} < 9'(DEPTH);

    atbc_keystore #(.DEPTH(DEPTH), .AW(AW)) u_keys (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (kidx[AW-1:0]),
        .i_wdata (i_in.payload[287:256]),
        .i_row   (r_step),
        .o_row   (keys)
    );

    assign ctrl.dec   = r_dec;
    assign ctrl.odd   = r_step[0];
    assign ctrl.last  = r_step == SW'(STEPS);
    assign ctrl.first = r_step == SW'(STEPS);

    atbc_round u_round (
        .i_ctrl  (ctrl),
        .i_state (r_data),
        .i_keys  (keys),
        .i_tweak (r_tweak),
        .o_state (step_out)
    );

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            atbc_pkg::S_IDLE: begin
                if (acc && (kind == atbc_pkg::K_ENC || kind == atbc_pkg::K_DEC)) begin
                    n_state = atbc_pkg::S_WAIT;
                    n_step  = (kind == atbc_pkg::K_DEC) ? SW'(STEPS) : '0;
                end
            end
            atbc_pkg::S_FETCH: n_state = atbc_pkg::S_WAIT;
            atbc_pkg::S_WAIT:  n_state = atbc_pkg::S_STEP;
            atbc_pkg::S_STEP: begin
                if (r_dec ? r_step == '0 : r_step == SW'(STEPS)) begin
                    n_state = atbc_pkg::S_OUT;
                end else begin
                    n_state = atbc_pkg::S_WAIT;
                    n_step  = r_dec ? r_step - 1'b1 : r_step + 1'b1;
                end
            end
            atbc_pkg::S_OUT: begin
                if (o_out.ready) n_state = atbc_pkg::S_IDLE;
            end
            default: n_state = atbc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready    = r_state == atbc_pkg::S_IDLE;
        o_out.valid   = r_state == atbc_pkg::S_OUT;
        o_out.payload = r_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= atbc_pkg::S_IDLE;
            r_step  <= '0;
            r_tweak <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_we && i_cfg_idx == 1'b0) r_tweak[127:64] <= i_cfg_data;
            if (i_cfg_we && i_cfg_idx == 1'b1) r_tweak[63:0]   <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == atbc_pkg::S_IDLE && acc) begin
            r_data <= i_in.payload[255:0];
            r_dec  <= kind == atbc_pkg::K_DEC;
        end else if (r_state == atbc_pkg::S_STEP) begin
            r_data <= step_out;
        end
    end
endmodule
